>>> hdl/assert_macros.svh
// assertion macros shared by the roi mean extractor rtl
// no dependencies; bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every rising edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

>>> hdl/crme_pkg.sv
// shared constants, types and register codes for the roi mean extractor
// no dependencies
package crme_pkg;

  // frame geometry
  localparam int MAX_DIM    = 4096;
  localparam int DIM_W      = $clog2(MAX_DIM);
  localparam int FWIDTH_W   = DIM_W + 1;
  localparam int MAX_RADIUS = 63;
  localparam int RAD_W      = 6;
  localparam int SQ_W       = 2 * RAD_W;

  // datapath widths
  localparam int PIX_W      = 16;
  localparam int SUM_W      = 30;
  localparam int CNT_W      = 14;
  localparam int MEAN_W     = 20;
  localparam int FRAC_BITS  = 4;
  localparam int DIVIDEND_W = SUM_W + FRAC_BITS;
  localparam int STEP_W     = $clog2(DIVIDEND_W);
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X         = 3'd0,
    REG_CENTER_Y         = 3'd1,
    REG_ROI_RADIUS       = 3'd2,
    REG_BACKGROUND_LEVEL = 3'd3,
    REG_FRAME_WIDTH      = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [DIM_W-1:0]    center_x;
    logic [DIM_W-1:0]    center_y;
    logic [RAD_W-1:0]    roi_radius;
    logic [PIX_W-1:0]    background_level;
    logic [FWIDTH_W-1:0] frame_width;
  } crme_cfg_t;

  // one frame's totals handed from front to back
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } crme_acc_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_HOLD
  } back_state_t;

endpackage

>>> hdl/crme_pixel_if.sv
// pixel channel: valid/ready handshake carrying one camera sample per item
// depends on crme_pkg
interface crme_pixel_if import crme_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;
  logic             frame_end;

  modport source (output valid, output pixel_value, output frame_end, input ready);
  modport sink   (input valid, input pixel_value, input frame_end, output ready);
endinterface

>>> hdl/crme_result_if.sv
// result channel: valid/ready handshake carrying one frame result per item
// depends on crme_pkg
interface crme_result_if import crme_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MEAN_W-1:0] mean_x16;
  logic [CNT_W-1:0]  pixel_total;
  logic              roi_empty;

  modport source (output valid, output mean_x16, output pixel_total, output roi_empty,
                  input ready);
  modport sink   (input valid, input mean_x16, input pixel_total, input roi_empty,
                  output ready);
endinterface

>>> hdl/crme_front.sv
// front end: position counters, disk test and per-frame accumulation
// depends on crme_pkg, crme_pixel_if and assert_macros.svh
`include "assert_macros.svh"
module crme_front import crme_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  crme_cfg_t          cfg,
  crme_pixel_if.sink         pixel_in,
  input  logic               q_full,
  output logic               push,
  output crme_acc_t          push_acc
);

  logic [DIM_W-1:0]    column_count;
  logic [DIM_W-1:0]    row_count;
  logic [SUM_W-1:0]    roi_sum;
  logic [CNT_W-1:0]    roi_count;

  logic                accept;
  logic [DIM_W-1:0]    adx;
  logic [DIM_W-1:0]    ady;
  logic                near;
  logic [SQ_W-1:0]     dx2;
  logic [SQ_W-1:0]     dy2;
  logic [SQ_W:0]       dist2;
  logic [SQ_W-1:0]     r2;
  logic                in_disk;
  logic                take;
  logic [PIX_W-1:0]    level;
  logic [SUM_W-1:0]    sum_upd;
  logic [CNT_W-1:0]    count_upd;
  logic [FWIDTH_W-1:0] col_inc;
  logic [FWIDTH_W-1:0] row_inc;
  logic                col_wrap;
  logic                row_wrap;

  // handshake: stall only when the queue cannot take a frame result
  assign pixel_in.ready = !q_full;
  assign accept         = pixel_in.valid && pixel_in.ready;

  // distance to the centre, rejected early when beyond the largest radius
  assign adx  = (column_count >= cfg.center_x) ? column_count - cfg.center_x
                                               : cfg.center_x - column_count;
  assign ady  = (row_count >= cfg.center_y) ? row_count - cfg.center_y
                                            : cfg.center_y - row_count;
  assign near = (adx <= DIM_W'(MAX_RADIUS)) && (ady <= DIM_W'(MAX_RADIUS));

  // small squares on the low bits only
  assign dx2     = adx[RAD_W-1:0] * adx[RAD_W-1:0];
  assign dy2     = ady[RAD_W-1:0] * ady[RAD_W-1:0];
  assign dist2   = {1'b0, dx2} + {1'b0, dy2};
  assign r2      = cfg.roi_radius * cfg.roi_radius;
  assign in_disk = near && (dist2 <= {1'b0, r2});

  // background removal clamped at zero, count saturates
  assign take      = accept && in_disk && (roi_count != COUNT_MAX);
  assign level     = (pixel_in.pixel_value > cfg.background_level)
                     ? pixel_in.pixel_value - cfg.background_level : '0;
  assign sum_upd   = take ? roi_sum + SUM_W'(level) : roi_sum;
  assign count_upd = take ? roi_count + CNT_W'(1) : roi_count;

  // frame result goes to the queue with the last pixel included
  assign push           = accept && pixel_in.frame_end;
  assign push_acc.sum   = sum_upd;
  assign push_acc.count = count_upd;

  // raster position stepping
  assign col_inc  = {1'b0, column_count} + FWIDTH_W'(1);
  assign row_inc  = {1'b0, row_count} + FWIDTH_W'(1);
  assign col_wrap = (col_inc == cfg.frame_width) || (col_inc >= FWIDTH_W'(MAX_DIM));
  assign row_wrap = (row_inc >= FWIDTH_W'(MAX_DIM));

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      roi_sum      <= '0;
      roi_count    <= '0;
    end else if (accept) begin
      if (pixel_in.frame_end) begin
        column_count <= '0;
        row_count    <= '0;
        roi_sum      <= '0;
        roi_count    <= '0;
      end else begin
        roi_sum   <= sum_upd;
        roi_count <= count_upd;
        if (col_wrap) begin
          column_count <= '0;
          row_count    <= row_wrap ? '0 : row_inc[DIM_W-1:0];
        end else begin
          column_count <= col_inc[DIM_W-1:0];
        end
      end
    end
  end

  `ASSERT_PROP(a_frame_clears, clk, rst, push |=> !(|{column_count, row_count, roi_count, roi_sum}))
  `ASSERT_NEVER(a_push_when_full, clk, rst, push && q_full)

endmodule

>>> hdl/crme_queue.sv
// short queue of frame totals between front and back
// depends on crme_pkg and assert_macros.svh
`include "assert_macros.svh"
module crme_queue import crme_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  crme_acc_t push_acc,
  output logic      full,
  input  logic      pop,
  output crme_acc_t pop_acc,
  output logic      empty
);

  crme_acc_t            entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    wr_ptr;
  logic [QPTR_W-1:0]    rd_ptr;
  logic [QFILL_W-1:0]   fill;

  assign full    = (fill == QFILL_W'(QUEUE_DEPTH));
  assign empty   = (fill == '0);
  assign pop_acc = entries[rd_ptr];

  // payload store
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_acc;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QFILL_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QFILL_W'(1);
      end
    end
  end

  `ASSERT_NEVER(a_overfill, clk, rst, fill > QFILL_W'(QUEUE_DEPTH))
  `ASSERT_NEVER(a_pop_empty, clk, rst, pop && empty)

endmodule

>>> hdl/crme_back.sv
// back end: bit-serial mean division and result output register
// depends on crme_pkg, crme_result_if and assert_macros.svh
`include "assert_macros.svh"
module crme_back import crme_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  crme_acc_t   q_acc,
  output logic        pop,
  crme_result_if.source result_out
);

  back_state_t            state;
  back_state_t            state_next;
  logic [CNT_W-1:0]       divisor;
  logic [CNT_W-1:0]       rem;
  logic [DIVIDEND_W-1:0]  quo;
  logic [STEP_W-1:0]      step;
  logic                   out_valid;
  logic [MEAN_W-1:0]      out_mean;
  logic [CNT_W-1:0]       out_total;
  logic                   out_empty;

  logic                   load_out;
  logic [CNT_W:0]         shifted;
  logic [CNT_W:0]         diff;
  logic                   ge;
  logic                   last_step;

  // one quotient bit per cycle
  assign shifted   = {rem, quo[DIVIDEND_W-1]};
  assign diff      = shifted - {1'b0, divisor};
  assign ge        = (shifted >= {1'b0, divisor});
  assign last_step = (step == STEP_W'(DIVIDEND_W - 1));

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and control
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          pop        = 1'b1;
          state_next = BK_DIV;
        end
      end
      BK_DIV: begin
        if (last_step) begin
          state_next = BK_HOLD;
        end
      end
      BK_HOLD: begin
        if (!out_valid || result_out.ready) begin
          load_out   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // divider datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      divisor <= q_acc.count;
      rem     <= '0;
      quo     <= {q_acc.sum, {FRAC_BITS{1'b0}}};
      step    <= '0;
    end else if (state == BK_DIV) begin
      rem  <= ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      quo  <= {quo[DIVIDEND_W-2:0], ge};
      step <= step + STEP_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_total <= divisor;
      out_empty <= (divisor == '0);
      out_mean  <= (divisor == '0) ? '0 : quo[MEAN_W-1:0];
    end
  end

  assign result_out.valid       = out_valid;
  assign result_out.mean_x16    = out_mean;
  assign result_out.pixel_total = out_total;
  assign result_out.roi_empty   = out_empty;

  `ASSERT_PROP(a_empty_mean_zero, clk, rst, (out_valid && out_empty) |-> !(|{out_mean, out_total}))
  `ASSERT_PROP(a_pop_starts_div, clk, rst, pop |=> (state == BK_DIV && step == '0))

endmodule

>>> hdl/circular_roi_mean_extractor.sv
// Circular ROI mean extractor. Pixels enter in raster order at one per clock on pixel_in; the
// last pixel of a frame carries frame_end. Each pixel inside the disk of radius roi_radius
// around (center_x, center_y) has background_level removed (clamped at zero) and is summed
// and counted. Once the frame_end pixel is taken, the frame totals go into a two-entry queue
// and a bit-serial divider produces 16*sum/count, truncated, one quotient bit per cycle; it
// pops the next totals only after loading its result into the output register, so pixel_in
// stalls only when two finished frames are still waiting in the queue. The user must see that
// configuration registers are written through cfg_we/cfg_index/cfg_wdata only while the block
// is idle; the block itself does not enforce this. Unknown indexes are ignored.
// depends on crme_pkg, crme_pixel_if, crme_result_if, crme_front, crme_queue, crme_back
module circular_roi_mean_extractor import crme_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  crme_pixel_if.sink            pixel_in,
  crme_result_if.source         result_out
);

  crme_cfg_t cfg;
  logic      q_full;
  logic      q_empty;
  logic      push;
  logic      pop;
  crme_acc_t push_acc;
  crme_acc_t pop_acc;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x         <= '0;
      cfg.center_y         <= '0;
      cfg.roi_radius       <= RAD_W'(8);
      cfg.background_level <= PIX_W'(35);
      cfg.frame_width      <= FWIDTH_W'(512);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CENTER_X:         cfg.center_x         <= cfg_wdata[DIM_W-1:0];
        REG_CENTER_Y:         cfg.center_y         <= cfg_wdata[DIM_W-1:0];
        REG_ROI_RADIUS:       cfg.roi_radius       <= cfg_wdata[RAD_W-1:0];
        REG_BACKGROUND_LEVEL: cfg.background_level <= cfg_wdata[PIX_W-1:0];
        REG_FRAME_WIDTH:      cfg.frame_width      <= cfg_wdata[FWIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  // pixel side
  crme_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .pixel_in (pixel_in),
    .q_full   (q_full),
    .push     (push),
    .push_acc (push_acc)
  );

  // frame totals queue
  crme_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_acc (push_acc),
    .full     (q_full),
    .pop      (pop),
    .pop_acc  (pop_acc),
    .empty    (q_empty)
  );

  // division and result side
  crme_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_acc      (pop_acc),
    .pop        (pop),
    .result_out (result_out)
  );

endmodule
